// ===== rtl/lsu_pkg.sv =====
`default_nettype none

package lsu_pkg;

  // Default depth of the queue between decode and execute
  localparam int LSU_QUEUE_DEPTH = 2;

  // Result word kinds
  typedef enum logic [2:0] {
    KIND_READ        = 3'd0,
    KIND_WRITE       = 3'd1,
    KIND_DONE        = 3'd2,
    KIND_UNSUPPORTED = 3'd3,
    KIND_PROTOCOL    = 3'd4
  } kind_t;

  // Register file indexes (code 6 of an operand field means memory)
  localparam logic [2:0] IDX_B = 3'd0;
  localparam logic [2:0] IDX_C = 3'd1;
  localparam logic [2:0] IDX_D = 3'd2;
  localparam logic [2:0] IDX_E = 3'd3;
  localparam logic [2:0] IDX_H = 3'd4;
  localparam logic [2:0] IDX_L = 3'd5;
  localparam logic [2:0] IDX_A = 3'd6;

  // Targets of LD rr,nn
  localparam logic [1:0] PAIR_BC = 2'd0;
  localparam logic [1:0] PAIR_DE = 2'd1;
  localparam logic [1:0] PAIR_HL = 2'd2;
  localparam logic [1:0] PAIR_SP = 2'd3;

  // Operation classes produced by the decoder
  typedef enum logic [3:0] {
    OP_DATA,    // memory read data returned
    OP_MOVE,    // LD r,r'
    OP_LDI,     // LD r,n
    OP_READ,    // any load from memory
    OP_WRITE,   // any single-byte store
    OP_LD16,    // LD rr,nn
    OP_SPST,    // LD (nn),SP
    OP_SPHL,    // LD SP,HL
    OP_HLSPE,   // LD HL,SP+e
    OP_UNSUP
  } op_t;

  // Address sources
  typedef enum logic [2:0] {
    ADDR_BC,
    ADDR_DE,
    ADDR_HL,
    ADDR_NN,
    ADDR_FFC,
    ADDR_FFN
  } addr_t;

  typedef enum logic [1:0] {
    STEP_NONE,
    STEP_INC,
    STEP_DEC
  } step_t;

  // One decoded word as it travels through the queue
  typedef struct packed {
    op_t        op;
    addr_t      addr_sel;
    step_t      hl_step;
    logic [2:0] src;
    logic [2:0] dst;
    logic       use_imm;
    logic [1:0] pair;
    logic [7:0] imm_low;
    logic [7:0] imm_high;
    logic [7:0] read_data;
  } item_t;

endpackage

`default_nettype wire

// ===== rtl/lsu_front.sv =====
`default_nettype none

module lsu_front import lsu_pkg::*; (
  input  wire logic       command,
  input  wire logic [7:0] opcode,
  input  wire logic [7:0] imm_low,
  input  wire logic [7:0] imm_high,
  input  wire logic [7:0] read_data,
  output item_t           item
);

  // Operand code to register index; A sits at code 7
  function automatic logic [2:0] reg_index(input logic [2:0] code);
    reg_index = (code == 3'd7) ? IDX_A : code;
  endfunction

  logic [2:0] fld_src;
  logic [2:0] fld_dst;

  assign fld_src = opcode[2:0];
  assign fld_dst = opcode[5:3];

  // Classify the word
  always_comb begin
    item           = '0;
    item.op        = OP_UNSUP;
    item.addr_sel  = ADDR_HL;
    item.hl_step   = STEP_NONE;
    item.imm_low   = imm_low;
    item.imm_high  = imm_high;
    item.read_data = read_data;
    item.pair      = opcode[5:4];
    item.src       = reg_index(fld_src);
    item.dst       = reg_index(fld_dst);

    if (command) begin
      item.op = OP_DATA;
    end else if (opcode[7:6] == 2'b01 && opcode != 8'h76) begin
      // LD r,r' with (HL) on either side
      if (fld_src == 3'd6) begin
        item.op = OP_READ;
      end else if (fld_dst == 3'd6) begin
        item.op = OP_WRITE;
      end else begin
        item.op = OP_MOVE;
      end
    end else if ((opcode & 8'hC7) == 8'h06) begin
      // LD r,n and LD (HL),n
      if (fld_dst == 3'd6) begin
        item.op      = OP_WRITE;
        item.use_imm = 1'b1;
      end else begin
        item.op = OP_LDI;
      end
    end else if ((opcode & 8'hC7) == 8'h02) begin
      // A through (BC) (DE) (HL+) (HL-)
      item.op  = fld_dst[0] ? OP_READ : OP_WRITE;
      item.src = IDX_A;
      item.dst = IDX_A;
      case (fld_dst[2:1])
        2'd0: item.addr_sel = ADDR_BC;
        2'd1: item.addr_sel = ADDR_DE;
        2'd2: item.hl_step  = STEP_INC;
        default: item.hl_step = STEP_DEC;
      endcase
    end else if ((opcode & 8'hCF) == 8'h01) begin
      item.op = OP_LD16;
    end else begin
      item.src = IDX_A;
      item.dst = IDX_A;
      case (opcode)
        8'hEA: begin item.op = OP_WRITE; item.addr_sel = ADDR_NN;  end
        8'hFA: begin item.op = OP_READ;  item.addr_sel = ADDR_NN;  end
        8'hE2: begin item.op = OP_WRITE; item.addr_sel = ADDR_FFC; end
        8'hF2: begin item.op = OP_READ;  item.addr_sel = ADDR_FFC; end
        8'hE0: begin item.op = OP_WRITE; item.addr_sel = ADDR_FFN; end
        8'hF0: begin item.op = OP_READ;  item.addr_sel = ADDR_FFN; end
        8'h08: item.op = OP_SPST;
        8'hF9: item.op = OP_SPHL;
        8'hF8: item.op = OP_HLSPE;
        default: item.op = OP_UNSUP;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lsu_queue.sv =====
`default_nettype none

module lsu_queue import lsu_pkg::*; #(
  parameter int Depth = LSU_QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  item_t     push_item,
  output logic      full,
  input  wire logic pop,
  output logic      head_valid,
  output item_t     head_item
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  item_t           slots [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign full       = (count == FullCnt);
  assign head_valid = (count != '0);
  assign head_item  = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lsu_back.sv =====
`default_nettype none

module lsu_back import lsu_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        head_valid,
  input  item_t            head_item,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       kind,
  output logic [15:0]      mem_address,
  output logic [7:0]       write_data,
  output logic [7:0]       acc_value,
  output logic [15:0]      bc_value,
  output logic [15:0]      de_value,
  output logic [15:0]      hl_value,
  output logic [15:0]      sp_value,
  output logic [3:0]       flag_bits,
  output logic             last
);

  // Architectural state
  logic [7:0]  a, b, c, d, e, h, l;
  logic [7:0]  a_next, b_next, c_next, d_next, e_next, h_next, l_next;
  logic [15:0] sp, sp_next;
  logic [3:0]  flags, flags_next;
  logic        pending, pending_next;
  logic [2:0]  pending_dest, pending_dest_next;
  logic        phase, phase_next;

  // Result of the word being executed
  logic [2:0]  res_kind;
  logic [15:0] res_addr;
  logic [7:0]  res_data;
  logic        res_last;

  logic        can_load;
  logic        fire;
  logic [15:0] hl;
  logic [15:0] nn;
  logic [15:0] addr;
  logic [15:0] hl_stepped;
  logic [15:0] sp_sum;
  logic [4:0]  half_sum;
  logic [8:0]  byte_sum;
  logic [7:0]  src_val;
  logic        wr_en;
  logic [2:0]  wr_idx;
  logic [7:0]  wr_val;

  function automatic logic [7:0] read_reg(
    input logic [2:0] idx,
    input logic [7:0] rb, rc, rd, re, rh, rl, ra
  );
    case (idx)
      IDX_B:   read_reg = rb;
      IDX_C:   read_reg = rc;
      IDX_D:   read_reg = rd;
      IDX_E:   read_reg = re;
      IDX_H:   read_reg = rh;
      IDX_L:   read_reg = rl;
      default: read_reg = ra;
    endcase
  endfunction

  // The output register takes a new word when empty or being drained
  assign can_load = !out_valid || !out_stall;
  assign fire     = head_valid && can_load;

  assign hl      = {h, l};
  assign nn      = {head_item.imm_high, head_item.imm_low};
  assign src_val = read_reg(head_item.src, b, c, d, e, h, l, a);

  // Address select
  always_comb begin
    case (head_item.addr_sel)
      ADDR_BC:  addr = {b, c};
      ADDR_DE:  addr = {d, e};
      ADDR_NN:  addr = nn;
      ADDR_FFC: addr = {8'hFF, c};
      ADDR_FFN: addr = {8'hFF, head_item.imm_low};
      default:  addr = hl;
    endcase
  end

  // HL post-increment or post-decrement
  assign hl_stepped = (head_item.hl_step == STEP_DEC) ? hl - 16'd1 : hl + 16'd1;

  // SP plus signed offset, with carries out of bits 3 and 7
  assign sp_sum   = sp + {{8{head_item.imm_low[7]}}, head_item.imm_low};
  assign half_sum = {1'b0, sp[3:0]} + {1'b0, head_item.imm_low[3:0]};
  assign byte_sum = {1'b0, sp[7:0]} + {1'b0, head_item.imm_low};

  // Execute
  always_comb begin
    b_next            = b;
    c_next            = c;
    d_next            = d;
    e_next            = e;
    h_next            = h;
    l_next            = l;
    a_next            = a;
    sp_next           = sp;
    flags_next        = flags;
    pending_next      = pending;
    pending_dest_next = pending_dest;
    phase_next        = phase;
    res_kind          = KIND_DONE;
    res_addr          = '0;
    res_data          = '0;
    res_last          = 1'b1;
    pop               = 1'b0;
    wr_en             = 1'b0;
    wr_idx            = head_item.dst;
    wr_val            = src_val;

    if (fire) begin
      pop = 1'b1;
      if (head_item.op == OP_DATA) begin
        if (!pending) begin
          res_kind = KIND_PROTOCOL;
        end else begin
          wr_en        = 1'b1;
          wr_idx       = pending_dest;
          wr_val       = head_item.read_data;
          pending_next = 1'b0;
        end
      end else if (pending) begin
        res_kind = KIND_PROTOCOL;
      end else begin
        case (head_item.op)
          OP_MOVE: begin
            wr_en = 1'b1;
          end
          OP_LDI: begin
            wr_en  = 1'b1;
            wr_val = head_item.imm_low;
          end
          OP_READ: begin
            res_kind          = KIND_READ;
            res_addr          = addr;
            pending_next      = 1'b1;
            pending_dest_next = head_item.dst;
          end
          OP_WRITE: begin
            res_kind = KIND_WRITE;
            res_addr = addr;
            res_data = head_item.use_imm ? head_item.imm_low : src_val;
          end
          OP_LD16: begin
            case (head_item.pair)
              PAIR_BC: {b_next, c_next} = nn;
              PAIR_DE: {d_next, e_next} = nn;
              PAIR_HL: {h_next, l_next} = nn;
              default: sp_next = nn;
            endcase
          end
          OP_SPST: begin
            res_kind = KIND_WRITE;
            if (!phase) begin
              // low byte first; the word stays at the queue head
              pop        = 1'b0;
              phase_next = 1'b1;
              res_addr   = nn;
              res_data   = sp[7:0];
              res_last   = 1'b0;
            end else begin
              phase_next = 1'b0;
              res_addr   = nn + 16'd1;
              res_data   = sp[15:8];
            end
          end
          OP_SPHL: begin
            sp_next = hl;
          end
          OP_HLSPE: begin
            {h_next, l_next} = sp_sum;
            flags_next       = {2'b00, half_sum[4], byte_sum[8]};
          end
          default: begin
            res_kind = KIND_UNSUPPORTED;
          end
        endcase
        // HL+ and HL- update the pair with the access
        if ((head_item.op == OP_READ || head_item.op == OP_WRITE) &&
            head_item.hl_step != STEP_NONE) begin
          {h_next, l_next} = hl_stepped;
        end
      end
    end

    // Single register write port
    if (wr_en) begin
      case (wr_idx)
        IDX_B:   b_next = wr_val;
        IDX_C:   c_next = wr_val;
        IDX_D:   d_next = wr_val;
        IDX_E:   e_next = wr_val;
        IDX_H:   h_next = wr_val;
        IDX_L:   l_next = wr_val;
        IDX_A:   a_next = wr_val;
        default: ;
      endcase
    end
  end

  // State and output word
  always_ff @(posedge clk) begin
    if (rst) begin
      a            <= '0;
      b            <= '0;
      c            <= '0;
      d            <= '0;
      e            <= '0;
      h            <= '0;
      l            <= '0;
      sp           <= '0;
      flags        <= '0;
      pending      <= 1'b0;
      pending_dest <= '0;
      phase        <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      a            <= a_next;
      b            <= b_next;
      c            <= c_next;
      d            <= d_next;
      e            <= e_next;
      h            <= h_next;
      l            <= l_next;
      sp           <= sp_next;
      flags        <= flags_next;
      pending      <= pending_next;
      pending_dest <= pending_dest_next;
      phase        <= phase_next;
      if (can_load) begin
        out_valid <= fire;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      kind        <= res_kind;
      mem_address <= res_addr;
      write_data  <= res_data;
      last        <= res_last;
    end
  end

  // State only moves when a word enters the output register, so the
  // live registers match the word held there
  assign acc_value = a;
  assign bc_value  = {b, c};
  assign de_value  = {d, e};
  assign hl_value  = {h, l};
  assign sp_value  = sp;
  assign flag_bits = flags;

endmodule

`default_nettype wire

// ===== rtl/cpu8_load_store_unit.sv =====
// Load group of an 8-bit CPU: register moves, immediate loads, memory
// loads and stores, 16-bit loads and the SP/HL transfers.
// Input channel (in_valid/in_stall): one word per instruction, or one word
// carrying read_data for the read request issued earlier. Immediates
// travel in the word.
// Output channel (out_valid/out_stall): one result word per input word,
// two for LD (nn),SP; last marks the final one. Each result carries the
// register values after it.
// A taken input word passes the queue slot and then the output register,
// where out_valid rises; words ahead of it in the queue go first.
// Throughput: one input word per cycle while out_stall is low, set by the
// single execute stage; LD (nn),SP holds that stage for both its words.
// A two-word queue separates the decoder from the execute stage, so input
// is still taken while a result waits on a stalled receiver; in_stall
// rises only when that queue is full.
// Reset clears all registers, flags, the pending read, the queue and the
// output register.
`default_nettype none

module cpu8_load_store_unit import lsu_pkg::*; #(
  parameter int QueueDepth = LSU_QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        command,
  input  wire logic [7:0]  opcode,
  input  wire logic [7:0]  imm_low,
  input  wire logic [7:0]  imm_high,
  input  wire logic [7:0]  read_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       kind,
  output logic [15:0]      mem_address,
  output logic [7:0]       write_data,
  output logic [7:0]       acc_value,
  output logic [15:0]      bc_value,
  output logic [15:0]      de_value,
  output logic [15:0]      hl_value,
  output logic [15:0]      sp_value,
  output logic [3:0]       flag_bits,
  output logic             last
);

  item_t dec_item;
  item_t head_item;
  logic  head_valid;
  logic  pop;
  logic  full;

  assign in_stall = full;

  lsu_front u_front (
    .command   (command),
    .opcode    (opcode),
    .imm_low   (imm_low),
    .imm_high  (imm_high),
    .read_data (read_data),
    .item      (dec_item)
  );

  lsu_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (in_valid),
    .push_item  (dec_item),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  lsu_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head_item   (head_item),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind),
    .mem_address (mem_address),
    .write_data  (write_data),
    .acc_value   (acc_value),
    .bc_value    (bc_value),
    .de_value    (de_value),
    .hl_value    (hl_value),
    .sp_value    (sp_value),
    .flag_bits   (flag_bits),
    .last        (last)
  );

  // The low-byte store of LD (nn),SP is always followed by the high byte
  a_first_half_followed: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |=> out_valid)
    else $error("second store word missing");

  // Only the split SP store produces a non-final word
  a_not_last_is_write: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> kind == KIND_WRITE)
    else $error("non-final word is not a write");

  // Z and N are never set by this group
  a_zn_clear: assert property (@(posedge clk) disable iff (rst)
    flag_bits[3:2] == 2'b00)
    else $error("Z or N flag set");

  // Reset empties the output register
  a_reset_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

`default_nettype wire
